// ===== hw/rtl/prim_minimum_spanning_tree_assert.svh =====
// Assertion macros used by the pass engine RTL. The checks are left out of synthesis builds.
`ifndef PRIM_MINIMUM_SPANNING_TREE_ASSERT_SVH
`define PRIM_MINIMUM_SPANNING_TREE_ASSERT_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define PMST_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Antecedent this cycle, consequent on the next cycle.
`define PMST_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define PMST_ASSERT(name, clk, rst_n, prop)
`define PMST_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/pmst_pkg.sv =====
`timescale 1ns / 1ps

package pmst_pkg;

    // Sizing
    localparam int MaxVertices = 64;
    localparam int VertexW     = $clog2(MaxVertices);
    localparam int CountW      = 7;
    localparam int WeightW     = 24;
    localparam int AddrW       = $clog2(MaxVertices * MaxVertices);

    // Absent edge cost: 9999 in Q16.8
    localparam logic [WeightW-1:0] CostInf = WeightW'(9999 * 256);

    // Vertex count limits and reset value
    localparam logic [CountW-1:0] VertMin   = CountW'(2);
    localparam logic [CountW-1:0] VertMax   = CountW'(MaxVertices);
    localparam logic [CountW-1:0] VertReset = CountW'(64);

    // Input word: one matrix entry
    typedef struct packed {
        logic [WeightW-1:0] weight;
        logic               absent;
    } t_in_word;

    // Output word: one tree edge
    typedef struct packed {
        logic [VertexW-1:0] edge_from;
        logic [VertexW-1:0] edge_to;
        logic               last_edge;
    } t_out_word;

    // Per-vertex entry of the link memory
    typedef struct packed {
        logic [WeightW-1:0] cost;
        logic [VertexW-1:0] parent;
    } t_link_entry;

    // Pass engine control from the loader
    typedef struct packed {
        logic              start;
        logic [CountW-1:0] vert_n;
    } t_eng_ctl;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } t_eng_state;

endpackage

// ===== hw/rtl/pmst_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read per cycle
module pmst_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/pmst_engine.sv =====
`timescale 1ns / 1ps
`include "prim_minimum_spanning_tree_assert.svh"

// Prim pass engine. Each scan walks vertices 1..n-1 once: it relaxes the
// link cost with the row of the vertex added last (or loads row 0 on the
// first scan), writes it back for vertices outside the tree and tracks the cheapest of them.
module pmst_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pmst_pkg::t_eng_ctl                  i_ctl,
    output logic                                o_busy,
    output logic [pmst_pkg::AddrW-1:0]          o_wt_raddr,
    input  logic [pmst_pkg::WeightW-1:0]        i_wt_rdata,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output pmst_pkg::t_out_word                 o_out_data
);

    // State and scan registers
    pmst_pkg::t_eng_state                 r_state, n_state;
    logic [pmst_pkg::CountW-1:0]          r_n, n_n;
    logic                                 r_first, n_first;
    logic [pmst_pkg::VertexW-1:0]         r_prev, n_prev;
    logic [pmst_pkg::AddrW-1:0]           r_row, n_row;
    logic [pmst_pkg::VertexW-1:0]         r_k_rd, n_k_rd;
    logic                                 r_issuing, n_issuing;
    logic                                 r_rd_vld, n_rd_vld;
    logic [pmst_pkg::VertexW-1:0]         r_k_pipe, n_k_pipe;
    logic                                 r_last_pipe, n_last_pipe;
    logic [pmst_pkg::WeightW-1:0]         r_best, n_best;
    logic [pmst_pkg::VertexW-1:0]         r_pick, n_pick;
    logic [pmst_pkg::VertexW-1:0]         r_pick_par, n_pick_par;
    logic [pmst_pkg::MaxVertices-1:0]     r_in_tree, n_in_tree;
    logic [pmst_pkg::VertexW-1:0]         r_steps, n_steps;
    logic                                 r_out_valid, n_out_valid;
    pmst_pkg::t_out_word                  r_out_data, n_out_data;

    // Link memory port signals
    logic                                 w_link_we;
    logic [$bits(pmst_pkg::t_link_entry)-1:0] w_link_rdata;
    pmst_pkg::t_link_entry                w_old;
    pmst_pkg::t_link_entry                w_new;
    logic                                 w_k_last;
    logic                                 w_skip;
    logic [pmst_pkg::VertexW+pmst_pkg::CountW-1:0] w_row_prod;

    pmst_ram #(
        .Width ($bits(pmst_pkg::t_link_entry)),
        .Depth (pmst_pkg::MaxVertices)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_link_we),
        .i_waddr (r_k_pipe),
        .i_wdata (w_new),
        .i_raddr (r_k_rd),
        .o_rdata (w_link_rdata)
    );

    assign w_old      = w_link_rdata;
    assign o_wt_raddr = r_row + pmst_pkg::AddrW'(r_k_rd);
    assign w_k_last   = (pmst_pkg::CountW'(r_k_rd) == (r_n - pmst_pkg::CountW'(1)));
    assign w_skip     = r_in_tree[r_k_pipe];
    assign w_row_prod = (pmst_pkg::VertexW + pmst_pkg::CountW)'(r_pick) *
                        (pmst_pkg::VertexW + pmst_pkg::CountW)'(r_n);

    // Relaxation of the entry coming back from both memories
    always_comb begin
        if (r_first) begin
            w_new.cost   = i_wt_rdata;
            w_new.parent = '0;
        end else if (i_wt_rdata < w_old.cost) begin
            w_new.cost   = i_wt_rdata;
            w_new.parent = r_prev;
        end else begin
            w_new = w_old;
        end
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pmst_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issuing   <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_in_tree   <= '0;
        end else begin
            r_issuing   <= n_issuing;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
            r_in_tree   <= n_in_tree;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_first     <= n_first;
        r_prev      <= n_prev;
        r_row       <= n_row;
        r_k_rd      <= n_k_rd;
        r_k_pipe    <= n_k_pipe;
        r_last_pipe <= n_last_pipe;
        r_best      <= n_best;
        r_pick      <= n_pick;
        r_pick_par  <= n_pick_par;
        r_steps     <= n_steps;
        r_out_data  <= n_out_data;
    end

    // Next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_first     = r_first;
        n_prev      = r_prev;
        n_row       = r_row;
        n_k_rd      = r_k_rd;
        n_issuing   = r_issuing;
        n_rd_vld    = 1'b0;
        n_k_pipe    = r_k_pipe;
        n_last_pipe = r_last_pipe;
        n_best      = r_best;
        n_pick      = r_pick;
        n_pick_par  = r_pick_par;
        n_in_tree   = r_in_tree;
        n_steps     = r_steps;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        w_link_we   = 1'b0;

        // output word taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            pmst_pkg::ST_IDLE: begin
                if (i_ctl.start) begin
                    n_state    = pmst_pkg::ST_SCAN;
                    n_n        = i_ctl.vert_n;
                    n_in_tree  = pmst_pkg::MaxVertices'(1);
                    n_first    = 1'b1;
                    n_row      = '0;
                    n_prev     = '0;
                    n_steps    = '0;
                    n_k_rd     = pmst_pkg::VertexW'(1);
                    n_issuing  = 1'b1;
                    n_best     = pmst_pkg::CostInf;
                    n_pick     = '0;
                    n_pick_par = '0;
                end
            end

            pmst_pkg::ST_SCAN: begin
                // issue reads of vertex k in both memories
                if (r_issuing) begin
                    n_rd_vld    = 1'b1;
                    n_k_pipe    = r_k_rd;
                    n_last_pipe = w_k_last;
                    n_k_rd      = r_k_rd + pmst_pkg::VertexW'(1);
                    if (w_k_last) begin
                        n_issuing = 1'b0;
                    end
                end
                // relax, write back, track the minimum (strict, lowest index wins)
                if (r_rd_vld) begin
                    if (!w_skip) begin
                        w_link_we = 1'b1;
                        if (w_new.cost < r_best) begin
                            n_best     = w_new.cost;
                            n_pick     = r_k_pipe;
                            n_pick_par = w_new.parent;
                        end
                    end
                    if (r_last_pipe) begin
                        n_state = pmst_pkg::ST_EMIT;
                    end
                end
            end

            pmst_pkg::ST_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid          = 1'b1;
                    n_out_data.edge_from = r_pick_par;
                    n_out_data.edge_to   = r_pick;
                    n_out_data.last_edge = (pmst_pkg::CountW'(r_steps) ==
                                            (r_n - pmst_pkg::CountW'(2)));
                    n_in_tree[r_pick]    = 1'b1;
                    n_prev               = r_pick;
                    n_row                = w_row_prod[pmst_pkg::AddrW-1:0];
                    n_first              = 1'b0;
                    n_steps              = r_steps + pmst_pkg::VertexW'(1);
                    if (pmst_pkg::CountW'(r_steps) == (r_n - pmst_pkg::CountW'(2))) begin
                        n_state = pmst_pkg::ST_IDLE;
                    end else begin
                        n_state    = pmst_pkg::ST_SCAN;
                        n_k_rd     = pmst_pkg::VertexW'(1);
                        n_issuing  = 1'b1;
                        n_best     = pmst_pkg::CostInf;
                        n_pick     = '0;
                        n_pick_par = '0;
                    end
                end
            end

            default: begin
                n_state = pmst_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy      = (r_state != pmst_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A picked vertex is new to the tree unless no link was finite
    `PMST_ASSERT(a_pick_fresh, i_clk, i_rst_n,
        (r_state == pmst_pkg::ST_EMIT && r_pick != '0) |-> !r_in_tree[r_pick])

    // Vertex 0 is picked exactly when no cost beat infinity
    `PMST_ASSERT(a_pick_inf, i_clk, i_rst_n,
        (r_state == pmst_pkg::ST_EMIT) |->
        ((r_pick == '0) == (r_best == pmst_pkg::CostInf)))

    // Write-back never hits the entry being read in the same cycle
    `PMST_ASSERT(a_link_no_overlap, i_clk, i_rst_n,
        w_link_we |-> !(r_issuing && (r_k_pipe == r_k_rd)))

    // The final data of a scan leads to the emit state
    `PMST_ASSERT_NEXT(a_scan_end, i_clk, i_rst_n,
        (r_state == pmst_pkg::ST_SCAN && r_rd_vld && r_last_pipe),
        (r_state == pmst_pkg::ST_EMIT))

endmodule

// ===== hw/rtl/prim_minimum_spanning_tree.sv =====
// Dense Prim minimum spanning tree. Words carry one adjacency matrix entry
// each, in row-major order; vertex_count squared words make one matrix and
// are taken one per cycle into the weight memory. An absent entry is stored
// as 9999.0 (Q16.8), a cost that is never chosen. The word that completes the
// matrix starts the pass, which grows the tree from vertex 0 and emits
// vertex_count - 1 edge words, the final one flagged. Each of the n - 1
// scans reads one entry per cycle through the single read port of the
// weight memory, then emits one edge word; the input is stalled during the
// pass and output stalls hold the pass. Vertex counts below 2 act as 2 and
// above 64 as 64; the register is written while no pass is running.
`timescale 1ns / 1ps

module prim_minimum_spanning_tree (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  pmst_pkg::t_in_word           i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output pmst_pkg::t_out_word          o_out_data,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [pmst_pkg::CountW-1:0]  i_cfg_data
);

    logic [pmst_pkg::CountW-1:0]   r_vertex_count;
    logic [pmst_pkg::AddrW-1:0]    r_load_count;
    logic [pmst_pkg::CountW-1:0]   w_n_eff;
    logic [2*pmst_pkg::CountW-1:0] w_n_sq;
    logic [pmst_pkg::AddrW:0]      w_cnt_next;
    logic                          w_trigger;
    logic                          w_in_accept;
    logic                          w_busy;
    logic [pmst_pkg::WeightW-1:0]  w_wdata;
    logic [pmst_pkg::AddrW-1:0]    w_wt_raddr;
    logic [pmst_pkg::WeightW-1:0]  w_wt_rdata;
    pmst_pkg::t_eng_ctl            w_ctl;

    // Vertex count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= pmst_pkg::VertReset;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_vertex_count <= i_cfg_data;
        end
    end

    // Clamp to the supported range
    always_comb begin
        if (r_vertex_count < pmst_pkg::VertMin) begin
            w_n_eff = pmst_pkg::VertMin;
        end else if (r_vertex_count > pmst_pkg::VertMax) begin
            w_n_eff = pmst_pkg::VertMax;
        end else begin
            w_n_eff = r_vertex_count;
        end
    end

    // Matrix completes when the load count reaches n squared
    assign w_n_sq      = (2 * pmst_pkg::CountW)'(w_n_eff) * (2 * pmst_pkg::CountW)'(w_n_eff);
    assign w_cnt_next  = {1'b0, r_load_count} + (pmst_pkg::AddrW + 1)'(1);
    assign w_trigger   = ((2 * pmst_pkg::CountW)'(w_cnt_next) >= w_n_sq);
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count <= '0;
        end else if (w_in_accept) begin
            r_load_count <= w_trigger ? '0 : w_cnt_next[pmst_pkg::AddrW-1:0];
        end
    end

    // Weight memory: written while loading, read by the pass
    assign w_wdata = i_in_data.absent ? pmst_pkg::CostInf : i_in_data.weight;

    pmst_ram #(
        .Width (pmst_pkg::WeightW),
        .Depth (pmst_pkg::MaxVertices * pmst_pkg::MaxVertices)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_accept),
        .i_waddr (r_load_count),
        .i_wdata (w_wdata),
        .i_raddr (w_wt_raddr),
        .o_rdata (w_wt_rdata)
    );

    assign w_ctl.start  = w_in_accept && w_trigger;
    assign w_ctl.vert_n = w_n_eff;

    pmst_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_ctl),
        .o_busy      (w_busy),
        .o_wt_raddr  (w_wt_raddr),
        .i_wt_rdata  (w_wt_rdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    assign o_in_stall  = w_busy;
    assign o_cfg_ready = !w_busy;

endmodule
